/* hdl/cfxa_pkg.sv */
// Shared types, codes and arithmetic helpers for the complex fixed-point ALU.
package cfxa_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int QBITS = 32;

  typedef enum logic [2:0] {
    ACT_ADD  = 3'd0,
    ACT_SUB  = 3'd1,
    ACT_MUL  = 3'd2,
    ACT_DIV  = 3'd3,
    ACT_CONJ = 3'd4,
    ACT_INC  = 3'd5,
    ACT_DEC  = 3'd6,
    ACT_CMP  = 3'd7
  } action_t;

  typedef struct packed {
    action_t            action;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
  } req_t;

  typedef struct packed {
    logic signed [31:0] out_re;
    logic signed [31:0] out_im;
    logic               divide_by_zero;
    logic               saturated;
    logic               equal_flag;
    logic               less_flag;
    logic               greater_flag;
    logic               a_is_zero;
  } rsp_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [31:0] low;
    logic [31:0] q;
    logic        neg;
    logic        ovf;
  } lane_t;

  typedef struct packed {
    rsp_t        rsp;
    logic        is_div;
    logic [63:0] d;
    lane_t       re;
    lane_t       im;
  } div_t;

  // {sat, value} of a 33-bit signed sum clipped to 32 bits
  function automatic logic [32:0] sat33(input logic signed [32:0] v);
    logic [32:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? {1'b1, 32'h8000_0000} : {1'b1, 32'h7FFF_FFFF};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  // {sat, value} of a sign-magnitude number clipped to 32 bits
  function automatic logic [32:0] sat_sm(input logic neg, input logic [63:0] mag);
    logic [32:0] r;
    if (neg) begin
      if (mag > 64'h8000_0000) r = {1'b1, 32'h8000_0000};
      else r = {1'b0, 32'(32'd0 - mag[31:0])};
    end else begin
      if (mag > 64'h7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
      else r = {1'b0, mag[31:0]};
    end
    return r;
  endfunction

  function automatic logic signed [65:0] sprod(input logic [63:0] mag, input logic neg);
    logic signed [65:0] m;
    m = $signed({2'b00, mag});
    return neg ? -m : m;
  endfunction

  function automatic lane_t div_step(input lane_t x, input logic [63:0] d);
    logic [64:0] sh;
    lane_t       y;
    sh = {x.rem, x.low[31]};
    y = x;
    y.low = {x.low[30:0], 1'b0};
    if (sh >= {1'b0, d}) begin
      y.rem = 64'(sh - {1'b0, d});
      y.q = {x.q[30:0], 1'b1};
    end else begin
      y.rem = sh[63:0];
      y.q = {x.q[30:0], 1'b0};
    end
    return y;
  endfunction

  function automatic logic [32:0] lane_out(input lane_t x);
    logic [32:0] r;
    if (x.ovf) r = x.neg ? {1'b1, 32'h8000_0000} : {1'b1, 32'h7FFF_FFFF};
    else r = sat_sm(x.neg, 64'(x.q));
    return r;
  endfunction

endpackage

/* hdl/cfxa_front.sv */
// Front pipeline: operand prep, products, sums, magnitudes and divider setup.
module cfxa_front #(
  parameter int FRAC_BITS = cfxa_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  cfxa_pkg::req_t in_req,
  output logic           out_valid,
  output cfxa_pkg::div_t out_data
);
  import cfxa_pkg::*;

  localparam logic signed [32:0] ONE = 33'(1) << FRAC_BITS;
  localparam int NW = 64 + FRAC_BITS;

  logic [4:0] v_r;

  // stage 1
  action_t     act1_r;
  logic [31:0] m1_r [4];
  logic [3:0]  s1_r;
  logic [32:0] sre1_r, sim1_r;
  logic        eq1_r, az1_r;
  // stage 2
  action_t     act2_r;
  logic [63:0] p2_r [8];
  logic [3:0]  s2_r;
  logic [32:0] sre2_r, sim2_r;
  logic        eq2_r, az2_r;
  // stage 3
  action_t            act3_r;
  logic signed [65:0] t3_r [4];
  logic [63:0]        ma3_r, mb3_r;
  logic [32:0]        sre3_r, sim3_r;
  logic               eq3_r, az3_r;
  // stage 4
  action_t     act4_r;
  logic [63:0] g4_r [4];
  logic [3:0]  n4_r;
  logic [63:0] mb4_r;
  logic        lt4_r, gt4_r;
  logic [32:0] sre4_r, sim4_r;
  logic        eq4_r, az4_r;
  // stage 5
  div_t        d5_r;

  logic [31:0] m1_nxt [4];
  logic [3:0]  s1_nxt;
  logic [32:0] sre1_nxt, sim1_nxt;
  div_t        d5_nxt;

  always_comb begin
    logic signed [31:0] op [4];
    op[0] = in_req.a_re;
    op[1] = in_req.a_im;
    op[2] = in_req.b_re;
    op[3] = in_req.b_im;
    for (int k = 0; k < 4; k++) begin
      s1_nxt[k] = op[k][31];
      m1_nxt[k] = op[k][31] ? 32'(32'd0 - op[k]) : op[k];
    end
    case (in_req.action)
      ACT_ADD: begin
        sre1_nxt = sat33(33'(in_req.a_re) + 33'(in_req.b_re));
        sim1_nxt = sat33(33'(in_req.a_im) + 33'(in_req.b_im));
      end
      ACT_SUB: begin
        sre1_nxt = sat33(33'(in_req.a_re) - 33'(in_req.b_re));
        sim1_nxt = sat33(33'(in_req.a_im) - 33'(in_req.b_im));
      end
      ACT_CONJ: begin
        sre1_nxt = {1'b0, in_req.a_re};
        sim1_nxt = sat33(33'sd0 - 33'(in_req.a_im));
      end
      ACT_INC: begin
        sre1_nxt = sat33(33'(in_req.a_re) + ONE);
        sim1_nxt = sat33(33'(in_req.a_im) + ONE);
      end
      ACT_DEC: begin
        sre1_nxt = sat33(33'(in_req.a_re) - ONE);
        sim1_nxt = sat33(33'(in_req.a_im) - ONE);
      end
      default: begin
        sre1_nxt = {1'b0, in_req.a_re};
        sim1_nxt = {1'b0, in_req.a_im};
      end
    endcase
  end

  always_comb begin
    logic [32:0]   qre, qim, mre, mim;
    logic [NW-1:0] num [2];
    logic          ovf [2];
    mre = sat_sm(n4_r[0], g4_r[0] >> FRAC_BITS);
    mim = sat_sm(n4_r[1], g4_r[1] >> FRAC_BITS);
    for (int k = 0; k < 2; k++) begin
      num[k] = NW'(g4_r[k + 2]) << FRAC_BITS;
      ovf[k] = 97'(num[k]) >= {1'b0, mb4_r, 32'd0};
    end
    d5_nxt = '0;
    d5_nxt.d = mb4_r;
    d5_nxt.re.rem = 64'(num[0] >> 32);
    d5_nxt.re.low = num[0][31:0];
    d5_nxt.re.neg = n4_r[2];
    d5_nxt.re.ovf = ovf[0];
    d5_nxt.im.rem = 64'(num[1] >> 32);
    d5_nxt.im.low = num[1][31:0];
    d5_nxt.im.neg = n4_r[3];
    d5_nxt.im.ovf = ovf[1];
    d5_nxt.rsp.equal_flag = eq4_r;
    d5_nxt.rsp.less_flag = lt4_r;
    d5_nxt.rsp.greater_flag = gt4_r;
    d5_nxt.rsp.a_is_zero = az4_r;
    qre = sre4_r;
    qim = sim4_r;
    case (act4_r)
      ACT_MUL: begin
        qre = mre;
        qim = mim;
      end
      ACT_DIV: begin
        qre = '0;
        qim = '0;
        d5_nxt.rsp.divide_by_zero = (mb4_r == 64'd0);
        d5_nxt.is_div = (mb4_r != 64'd0);
      end
      default: ;
    endcase
    d5_nxt.rsp.out_re = qre[31:0];
    d5_nxt.rsp.out_im = qim[31:0];
    d5_nxt.rsp.saturated = qre[32] | qim[32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    act1_r <= in_req.action;
    m1_r <= m1_nxt;
    s1_r <= s1_nxt;
    sre1_r <= sre1_nxt;
    sim1_r <= sim1_nxt;
    eq1_r <= (in_req.a_re == in_req.b_re) && (in_req.a_im == in_req.b_im);
    az1_r <= (in_req.a_re == 32'sd0) && (in_req.a_im == 32'sd0);

    act2_r <= act1_r;
    p2_r[0] <= 64'(m1_r[0]) * 64'(m1_r[2]);
    p2_r[1] <= 64'(m1_r[1]) * 64'(m1_r[3]);
    p2_r[2] <= 64'(m1_r[0]) * 64'(m1_r[3]);
    p2_r[3] <= 64'(m1_r[1]) * 64'(m1_r[2]);
    p2_r[4] <= 64'(m1_r[0]) * 64'(m1_r[0]);
    p2_r[5] <= 64'(m1_r[1]) * 64'(m1_r[1]);
    p2_r[6] <= 64'(m1_r[2]) * 64'(m1_r[2]);
    p2_r[7] <= 64'(m1_r[3]) * 64'(m1_r[3]);
    s2_r <= s1_r;
    sre2_r <= sre1_r;
    sim2_r <= sim1_r;
    eq2_r <= eq1_r;
    az2_r <= az1_r;

    act3_r <= act2_r;
    t3_r[0] <= sprod(p2_r[0], s2_r[0] ^ s2_r[2]) - sprod(p2_r[1], s2_r[1] ^ s2_r[3]);
    t3_r[1] <= sprod(p2_r[2], s2_r[0] ^ s2_r[3]) + sprod(p2_r[3], s2_r[1] ^ s2_r[2]);
    t3_r[2] <= sprod(p2_r[0], s2_r[0] ^ s2_r[2]) + sprod(p2_r[1], s2_r[1] ^ s2_r[3]);
    t3_r[3] <= sprod(p2_r[3], s2_r[1] ^ s2_r[2]) - sprod(p2_r[2], s2_r[0] ^ s2_r[3]);
    ma3_r <= p2_r[4] + p2_r[5];
    mb3_r <= p2_r[6] + p2_r[7];
    sre3_r <= sre2_r;
    sim3_r <= sim2_r;
    eq3_r <= eq2_r;
    az3_r <= az2_r;

    act4_r <= act3_r;
    for (int k = 0; k < 4; k++) begin
      n4_r[k] <= t3_r[k][65];
      g4_r[k] <= t3_r[k][65] ? 64'(-t3_r[k]) : t3_r[k][63:0];
    end
    mb4_r <= mb3_r;
    lt4_r <= ma3_r < mb3_r;
    gt4_r <= ma3_r > mb3_r;
    sre4_r <= sre3_r;
    sim4_r <= sim3_r;
    eq4_r <= eq3_r;
    az4_r <= az3_r;

    d5_r <= d5_nxt;
  end

  assign out_valid = v_r[4];
  assign out_data = d5_r;

endmodule

/* hdl/cfxa_div.sv */
// Pipelined restoring divider, one quotient bit per stage for both lanes.
module cfxa_div #(
  parameter int STAGES = cfxa_pkg::QBITS
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  cfxa_pkg::div_t in_data,
  output logic           out_valid,
  output cfxa_pkg::div_t out_data
);
  import cfxa_pkg::*;

  logic [STAGES-1:0] vld_r;
  div_t              pipe_r [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    div_t src, nxt;
    logic src_v;
    if (k == 0) begin : g_first
      assign src = in_data;
      assign src_v = in_valid;
    end else begin : g_rest
      assign src = pipe_r[k-1];
      assign src_v = vld_r[k-1];
    end
    always_comb begin
      nxt = src;
      nxt.re = div_step(src.re, src.d);
      nxt.im = div_step(src.im, src.d);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= src_v;
      end
    end
    always_ff @(posedge clk) begin
      pipe_r[k] <= nxt;
    end
  end

  assign out_valid = vld_r[STAGES-1];
  assign out_data = pipe_r[STAGES-1];

endmodule

/* hdl/complex_fixed_point_alu.sv */
// Complex fixed-point ALU top level: front pipeline, divider and result register.
// Every action passes through the same front, divider and result register path.
// Throughput: one request per cycle; busy stays low, as the 32-stage divider is pipelined.
// The front uses five stages: operands, 32x32 products, sums, magnitudes, divide setup.
// Reset (synchronous, rst_n low) clears all valid bits; in-flight requests are dropped.
// Results appear for one cycle on out_valid; the receiver cannot stall.
module complex_fixed_point_alu #(
  parameter int FRAC_BITS = cfxa_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  cfxa_pkg::req_t in_req,
  output logic           out_valid,
  output cfxa_pkg::rsp_t out_rsp
);
  import cfxa_pkg::*;

  logic  f_valid, d_valid;
  div_t  f_data, d_data;
  logic  out_valid_r;
  rsp_t  out_rsp_r, rsp_nxt;

  assign busy = 1'b0;

  cfxa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start & ~busy),
    .in_req   (in_req),
    .out_valid(f_valid),
    .out_data (f_data)
  );

  cfxa_div #(.STAGES(QBITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (f_valid),
    .in_data  (f_data),
    .out_valid(d_valid),
    .out_data (d_data)
  );

  always_comb begin
    logic [32:0] lr, li;
    lr = lane_out(d_data.re);
    li = lane_out(d_data.im);
    rsp_nxt = d_data.rsp;
    if (d_data.is_div) begin
      rsp_nxt.out_re = lr[31:0];
      rsp_nxt.out_im = li[31:0];
      rsp_nxt.saturated = lr[32] | li[32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_rsp_r <= rsp_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rsp = out_rsp_r;

endmodule

/* hdl/cfxa_checker.sv */
// Port-level assertions for the complex fixed-point ALU, bound to the top level.
module cfxa_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input logic           out_valid,
  input cfxa_pkg::rsp_t out_rsp
);
  import cfxa_pkg::*;

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.divide_by_zero |->
      out_rsp.out_re == 32'sd0 && out_rsp.out_im == 32'sd0 && !out_rsp.saturated)
    else $error("zero divisor result not cleared");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_rsp.less_flag && out_rsp.greater_flag))
    else $error("less and greater both set");

  a_equal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.equal_flag |-> !out_rsp.less_flag && !out_rsp.greater_flag)
    else $error("equal operands report magnitude order");

  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy)
    else $error("request held off");

endmodule

bind complex_fixed_point_alu cfxa_checker u_chk (.*);
